// File: rtl/core/epcc_pkg.sv
// Shared types, codes and constants of the Euler path and cycle checker.
package epcc_pkg;

  // Field widths fixed by the item format
  localparam int OP_W      = 2;
  localparam int COUNT_W   = 7;
  localparam int LABEL_W   = 6;
  localparam int VERDICT_W = 2;

  // Default and largest number of vertex labels
  localparam int DEF_MAX_VERTICES = 64;

  // Odd-degree vertex count that makes an open trail
  localparam int PATH_ODD = 2;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_EDGE  = 2'd1,
    OP_EVAL  = 2'd2
  } op_t;

  typedef enum logic [VERDICT_W-1:0] {
    V_NONE  = 2'd0,
    V_PATH  = 2'd1,
    V_CYCLE = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EA_RD,
    S_EA_WR,
    S_EB_RD,
    S_EB_WR,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

// File: rtl/core/euler_path_cycle_check_unit.sv
// Top level of the Euler path and cycle checker: sequencer, masks and walk.
// Start, unused-code and out-of-range edge words leave the sequencer idle; an edge word
// steps through S_EA_RD, S_EA_WR, S_EB_RD and S_EB_WR, since both endpoint rows are
// updated by read-modify-write through the registered read port of the adjacency
// memory. An evaluate word sweeps the memory one row a cycle, repeating the sweep until
// the reached set stops growing; the sweeps that add a vertex are at most as many as the
// present vertices. The verdict sits in an output register, so the next word is taken
// while it waits.
module euler_path_cycle_check_unit
  import epcc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [COUNT_W-1:0]   in_vertex_count,
  input  logic [LABEL_W-1:0]   in_end_a,
  input  logic [LABEL_W-1:0]   in_end_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VERDICT_W-1:0] out_verdict
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [VW-1:0]           LAST_IDX = VW'(MAX_VERTICES - 1);
  localparam logic [MAX_VERTICES-1:0] ONE_BIT  = MAX_VERTICES'(1);

  state_t state_r, state_nxt;

  logic [VW-1:0]           a_r, b_r;
  logic [VW-1:0]           idx_r, ridx_r;
  logic                    pend_r;
  logic                    changed_r;
  logic                    first_r;
  logic [MAX_VERTICES-1:0] reached_r, present_r, odd_r;
  logic [COUNT_W-1:0]      expected_r;
  logic [CW-1:0]           cnt_p_r, cnt_o_r;
  logic                    out_valid_r;
  logic [VERDICT_W-1:0]    out_verdict_r;

  logic                    in_acc;
  logic                    labels_ok;
  logic [VW-1:0]           in_a, in_b;
  logic                    mem_clr, mem_we;
  logic [VW-1:0]           mem_waddr, mem_raddr;
  logic [MAX_VERTICES-1:0] mem_wdata, mem_rdata;
  logic [MAX_VERTICES-1:0] grown;
  logic                    changed_any;
  logic                    out_load;
  verdict_t                verdict;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign labels_ok = (int'(in_end_a) < MAX_VERTICES) && (int'(in_end_b) < MAX_VERTICES);
  assign in_a      = in_end_a[VW-1:0];
  assign in_b      = in_end_b[VW-1:0];

  // Merge the arriving row into the reached set when its vertex is reached
  assign grown       = reached_r | ((pend_r && reached_r[ridx_r]) ? mem_rdata : '0);
  assign changed_any = changed_r || (grown != reached_r);

  // Classify from the held counts and masks
  always_comb begin
    if (COUNT_W'(cnt_p_r) != expected_r) begin
      verdict = V_NONE;
    end else if ((present_r & ~reached_r) != '0) begin
      verdict = V_NONE;
    end else if (int'(cnt_o_r) > PATH_ODD) begin
      verdict = V_NONE;
    end else if (int'(cnt_o_r) == PATH_ODD) begin
      verdict = V_PATH;
    end else begin
      verdict = V_CYCLE;
    end
  end

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence the words and drive the memory port
  always_comb begin
    state_nxt = state_r;
    mem_clr   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = a_r;
    mem_wdata = mem_rdata | (ONE_BIT << b_r);
    mem_raddr = idx_r;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_START) begin
            mem_clr = 1'b1;
          end else if (in_operation == OP_EDGE && labels_ok) begin
            state_nxt = S_EA_RD;
          end else if (in_operation == OP_EVAL) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_EA_RD: begin
        mem_raddr = a_r;
        state_nxt = S_EA_WR;
      end
      S_EA_WR: begin
        mem_we    = 1'b1;
        state_nxt = S_EB_RD;
      end
      S_EB_RD: begin
        mem_raddr = b_r;
        state_nxt = S_EB_WR;
      end
      S_EB_WR: begin
        mem_we    = 1'b1;
        mem_waddr = b_r;
        mem_wdata = mem_rdata | (ONE_BIT << a_r);
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = changed_any ? S_SCAN : S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Capture edge endpoints
  always_ff @(posedge clk) begin
    if (in_acc && in_operation == OP_EDGE) begin
      a_r <= in_a;
      b_r <= in_b;
    end
  end

  // Update query masks and the expected count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      odd_r      <= '0;
      expected_r <= '0;
    end else if (in_acc && in_operation == OP_START) begin
      present_r  <= '0;
      odd_r      <= '0;
      expected_r <= in_vertex_count;
    end else if (in_acc && in_operation == OP_EDGE && labels_ok) begin
      present_r <= present_r | (ONE_BIT << in_a) | (ONE_BIT << in_b);
      odd_r     <= odd_r ^ (ONE_BIT << in_a) ^ (ONE_BIT << in_b);
    end
  end

  // Track reads in flight during a sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= (state_r == S_SCAN);
    end
  end

  // Run the connectivity sweeps and count present and odd vertices
  always_ff @(posedge clk) begin
    ridx_r <= idx_r;
    if (in_acc && in_operation == OP_START) begin
      reached_r <= '0;
    end
    if (in_acc && in_operation == OP_EVAL) begin
      reached_r <= present_r & (~present_r + ONE_BIT);
      idx_r     <= '0;
      changed_r <= 1'b0;
      first_r   <= 1'b1;
      cnt_p_r   <= '0;
      cnt_o_r   <= '0;
    end else begin
      if (state_r == S_SCAN && idx_r != LAST_IDX) begin
        idx_r <= idx_r + VW'(1);
      end
      if (pend_r) begin
        reached_r <= grown;
        if (first_r) begin
          cnt_p_r <= cnt_p_r + CW'(present_r[ridx_r]);
          cnt_o_r <= cnt_o_r + CW'(odd_r[ridx_r]);
        end
      end
      // Restart the sweep while it still grows, else note any growth
      if (state_r == S_DRAIN && changed_any) begin
        idx_r     <= '0;
        changed_r <= 1'b0;
        first_r   <= 1'b0;
      end else if (pend_r && grown != reached_r) begin
        changed_r <= 1'b1;
      end
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  epcc_adj_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_adj_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (mem_clr),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

`ifndef ASSERT_OFF
  // The reached set only grows within a sweep
  a_reached_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && $past(state_r == S_SCAN))
      |-> (($past(reached_r) & ~reached_r) == '0))
    else $error("reached set lost a vertex during a sweep");

  // A sweep reaches only vertices that appear on some edge
  a_reached_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_DRAIN || state_r == S_DONE)
      |-> ((reached_r & ~present_r) == '0))
    else $error("reached vertex is not present");

  // Odd vertices are a subset of present ones
  a_odd_le_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (cnt_o_r <= cnt_p_r))
    else $error("odd-degree count exceeds present count");

  // The memory is written only while an edge word is in progress
  a_write_in_edge: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ($past(state_r) == S_EA_RD || $past(state_r) == S_EB_RD))
    else $error("row write without a preceding row read");
`endif

endmodule

// File: rtl/core/epcc_adj_mem.sv
// Adjacency row memory with one valid bit per row and a registered read port.
module epcc_adj_mem #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              clr,
  input  logic                              wr_en,
  input  logic [$clog2(MAX_VERTICES)-1:0]   wr_addr,
  input  logic [MAX_VERTICES-1:0]           wr_data,
  input  logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
  output logic [MAX_VERTICES-1:0]           rd_data
);

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] valid_r;
  logic [MAX_VERTICES-1:0] rd_data_r;

  // Write a row; the array itself has no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track rows written since the last clear
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Register the read word; a row never written reads as empty
  always_ff @(posedge clk) begin
    rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

// File: test/verdict_tracker_pkg.sv
// Scoreboard class that predicts and checks the verdicts of the Euler path and cycle checker.
package verdict_tracker_pkg;
  import epcc_pkg::*;

  class verdict_tracker;
    int unsigned label_limit;
    bit [63:0]   adjacency [64];
    bit [63:0]   odd_mask;
    bit [63:0]   present_mask;
    bit [6:0]    expected_count;
    verdict_t    pending_verdicts [$];
    int          errors;
    int          checked;
    int          hits [3];

    function new(int unsigned limit);
      label_limit    = limit;
      expected_count = '0;
      errors         = 0;
      checked        = 0;
      hits           = '{0, 0, 0};
      clear_graph();
    endfunction

    // Drop every edge, parity bit and presence bit of the current query
    function void clear_graph();
      foreach (adjacency[i]) adjacency[i] = '0;
      odd_mask     = '0;
      present_mask = '0;
    endfunction

    // Count check, then flood from the lowest present vertex, then odd-degree count
    function verdict_t classify_graph();
      bit [63:0] reached;
      bit [63:0] grown;
      int        odd;
      int        v;
      if ($countones(present_mask) != int'(expected_count)) return V_NONE;
      if (present_mask != '0) begin
        reached = present_mask & (~present_mask + 64'd1);
        grown   = '0;
        while (grown != reached) begin
          grown = reached;
          for (v = 0; v < 64; v++) begin
            if (grown[v]) reached |= adjacency[v];
          end
        end
        if ((present_mask & ~reached) != '0) return V_NONE;
      end
      odd = $countones(odd_mask);
      if (odd > PATH_ODD) return V_NONE;
      if (odd == PATH_ODD) return V_PATH;
      return V_CYCLE;
    endfunction

    // Apply one accepted word to the graph copy; queue a verdict for evaluate words
    function void note_word(logic [OP_W-1:0] op, logic [COUNT_W-1:0] count,
                            logic [LABEL_W-1:0] a, logic [LABEL_W-1:0] b);
      case (op)
        OP_START: begin
          clear_graph();
          expected_count = count;
        end
        OP_EDGE: begin
          if (a < label_limit && b < label_limit) begin
            adjacency[a][b] = 1'b1;
            adjacency[b][a] = 1'b1;
            present_mask[a] = 1'b1;
            present_mask[b] = 1'b1;
            odd_mask[a]     = ~odd_mask[a];
            odd_mask[b]     = ~odd_mask[b];
          end
        end
        OP_EVAL: pending_verdicts = {pending_verdicts, classify_graph()};
        default: ;
      endcase
    endfunction

    // Compare one accepted verdict with the oldest pending one
    function void check_verdict(logic [VERDICT_W-1:0] got);
      verdict_t want;
      checked++;
      if (pending_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: verdict %0d arrived with none pending", got);
        return;
      end
      want = pending_verdicts.pop_front();
      hits[int'(want)]++;
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: verdict %0d: expected %0d (%s), actual %0d",
                   checked, want, want.name(), got);
        end
      end
    endfunction
  endclass

endpackage

// File: test/tb_euler_path_cycle_check_unit.sv
// Testbench of the Euler path and cycle checker: random graph queries, stalls, verdict checks.
module tb_euler_path_cycle_check_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import epcc_pkg::*;
  import verdict_tracker_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_WORDS  = 600;
  localparam int HOLD_CYCLES   = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef logic [LABEL_W-1:0] label_q_t [$];

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_operation    = '0;
  logic [COUNT_W-1:0]   in_vertex_count = '0;
  logic [LABEL_W-1:0]   in_end_a        = '0;
  logic [LABEL_W-1:0]   in_end_b        = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [VERDICT_W-1:0] out_verdict;

  verdict_tracker board = new(DEF_MAX_VERTICES);

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int words_sent     = 0;
  int cycle_count    = 0;
  label_q_t edge_a;
  label_q_t edge_b;

  euler_path_cycle_check_unit #(
    .MAX_VERTICES(DEF_MAX_VERTICES)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_vertex_count(in_vertex_count),
    .in_end_a       (in_end_a),
    .in_end_b       (in_end_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_verdict    (out_verdict)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one word after a random idle gap and hold it until accepted
  task automatic send_word(logic [OP_W-1:0] op, logic [COUNT_W-1:0] count,
                           logic [LABEL_W-1:0] a, logic [LABEL_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_vertex_count <= count;
    in_end_a        <= a;
    in_end_b        <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(op, count, a, b);
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic send_start(logic [COUNT_W-1:0] count);
    send_word(OP_START, count, LABEL_W'($urandom_range(63)), LABEL_W'($urandom_range(63)));
  endtask

  task automatic send_edge(logic [LABEL_W-1:0] a, logic [LABEL_W-1:0] b);
    send_word(OP_EDGE, COUNT_W'($urandom_range(127)), a, b);
  endtask

  task automatic send_eval();
    send_word(OP_EVAL, COUNT_W'($urandom_range(127)),
              LABEL_W'($urandom_range(63)), LABEL_W'($urandom_range(63)));
  endtask

  // Drop valid and wait until every queued verdict has been checked
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (board.pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Append the edges of a walk through all stops, with extra random revisits
  function automatic void add_walk(label_q_t stops, bit closed);
    label_q_t route;
    int       extra;
    int       i;
    route = stops;
    extra = $urandom_range(stops.size());
    repeat (extra) begin
      route.insert($urandom_range(route.size() - 1), stops[$urandom_range(stops.size() - 1)]);
    end
    if (closed) route = {route, route[0]};
    for (i = 0; i + 1 < route.size(); i++) begin
      if ($urandom_range(1) == 1) begin
        edge_a = {edge_a, route[i]};
        edge_b = {edge_b, route[i+1]};
      end else begin
        edge_a = {edge_a, route[i+1]};
        edge_b = {edge_b, route[i]};
      end
    end
  endfunction

  // Build one query on random labels, then send start, edges and evaluate words
  task automatic random_query(int max_n);
    label_q_t         labels;
    label_q_t         part_a;
    label_q_t         part_b;
    bit [63:0]        used;
    bit [63:0]        present;
    int               n;
    int               pick;
    int               count;
    int               cut;
    int               i;
    logic [LABEL_W-1:0] v;
    pick = $urandom_range(99);
    if (pick < 70) n = $urandom_range(6, 1);
    else if (pick < 95) n = $urandom_range(16, 7);
    else n = $urandom_range(64, 17);
    if (n > max_n) n = max_n;
    used = '0;
    while (labels.size() < n) begin
      v = LABEL_W'($urandom_range(63));
      if (!used[v]) begin
        used[v] = 1'b1;
        labels  = {labels, v};
      end
    end
    edge_a.delete();
    edge_b.delete();

    // Pick a shape: closed walk, open walk, scattered edges or two separate cycles
    pick = $urandom_range(99);
    if (pick < 35) begin
      add_walk(labels, 1'b1);
    end else if (pick < 70) begin
      add_walk(labels, 1'b0);
    end else if (pick < 85 || n < 2) begin
      repeat ($urandom_range(2 * n, 1)) begin
        edge_a = {edge_a, labels[$urandom_range(n - 1)]};
        edge_b = {edge_b, labels[$urandom_range(n - 1)]};
      end
    end else begin
      cut = $urandom_range(n - 1, 1);
      for (i = 0; i < n; i++) begin
        if (i < cut) part_a = {part_a, labels[i]};
        else part_b = {part_b, labels[i]};
      end
      add_walk(part_a, 1'b1);
      add_walk(part_b, 1'b1);
    end
    if ($urandom_range(4) == 0) begin
      v      = labels[$urandom_range(n - 1)];
      edge_a = {edge_a, v};
      edge_b = {edge_b, v};
    end

    // Mostly the true distinct count, sometimes off by one, zero or above the maximum
    present = '0;
    for (i = 0; i < edge_a.size(); i++) begin
      present[edge_a[i]] = 1'b1;
      present[edge_b[i]] = 1'b1;
    end
    count = $countones(present);
    pick  = $urandom_range(99);
    if (pick < 8) count = count + 1;
    else if (pick < 15 && count > 0) count = count - 1;
    else if (pick < 20) count = 0;
    else if (pick < 25) count = $urandom_range(127, 65);

    send_start(count[COUNT_W-1:0]);
    for (i = 0; i < edge_a.size(); i++) begin
      if ($urandom_range(19) == 0) begin
        send_word(OP_UNUSED, COUNT_W'($urandom_range(127)),
                  LABEL_W'($urandom_range(63)), LABEL_W'($urandom_range(63)));
      end
      send_edge(edge_a[i], edge_b[i]);
    end
    send_eval();
    if ($urandom_range(6) == 0) send_eval();
  endtask

  // Receiver: check accepted verdicts, then stall at random or for a long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_verdict(out_verdict);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog on total run length
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timed out after %0d cycles, %0d verdicts pending",
             cycle_count, board.pending_verdicts.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    int phase;
    int target;
    int total_errors;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: empty query straight out of reset
    send_eval();
    // No edges with a nonzero count
    send_start(7'd5);
    send_eval();
    // Count above the maximum, extreme labels
    send_start(7'd127);
    send_edge(6'd0, 6'd63);
    send_eval();
    // Single edge is a path; evaluate twice
    send_start(7'd2);
    send_edge(6'd63, 6'd0);
    send_eval();
    send_eval();
    // Self loop alone keeps parity even
    send_start(7'd1);
    send_edge(6'd63, 6'd63);
    send_eval();
    // Double edge is a cycle; unused code in between is ignored
    send_start(7'd2);
    send_edge(6'd0, 6'd1);
    send_edge(6'd1, 6'd0);
    send_word(OP_UNUSED, 7'd127, 6'd63, 6'd63);
    send_eval();
    // Two components
    send_start(7'd4);
    send_edge(6'd0, 6'd1);
    send_edge(6'd2, 6'd3);
    send_eval();
    // Star with four odd vertices
    send_start(7'd4);
    send_edge(6'd0, 6'd1);
    send_edge(6'd0, 6'd2);
    send_edge(6'd0, 6'd3);
    send_eval();
    wait_drain();

    // Random queries under four idle/stall mixes
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      target = words_sent + RANDOM_WORDS / 4;
      while (words_sent < target) random_query(64);
      wait_drain();
      // Hold the output off while small queries keep coming, so the input backs up
      if (phase == 0) begin
        hold_left = HOLD_CYCLES;
        repeat (4) random_query(4);
        wait_drain();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    total_errors = board.errors + board.pending_verdicts.size();
    $display("Sent %0d graph words over four idle/stall mixes plus one long output hold-off.",
             words_sent);
    $display("Checked %0d verdicts (none %0d, path %0d, cycle %0d), %0d errors.",
             board.checked, board.hits[0], board.hits[1], board.hits[2], total_errors);
    if (total_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
